@@ design/wsfl_pkg.sv @@
`timescale 1ns / 1ps
package wsfl_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int MAX_RESULTS    = 32;
  localparam int FUNC_W         = 2;
  localparam int SLOT_NUM_W     = 8;
  localparam int STATUS_W       = 2;
  localparam int SLOT_ID_W      = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LIST   = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_BAD_DEL   = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Link RAM read address source
  typedef enum logic [2:0] {
    RD_NONE,
    RD_FREE_HEAD,
    RD_USED_HEAD,
    RD_TARGET,
    RD_CUR,
    RD_LINK
  } rd_sel_e;

  // Link RAM write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_ALLOC,
    WR_UNLINK,
    WR_FREE
  } wr_sel_e;

  typedef enum logic [1:0] {
    ID_ZERO,
    ID_FREE,
    ID_TARGET,
    ID_CUR
  } id_sel_e;

  typedef struct packed {
    logic    capture;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    alloc_commit;
    logic    snext_load;
    logic    head_unlink;
    logic    free_commit;
    logic    cur_load_head;
    logic    cur_load_rd;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    emit;
    status_e emit_status;
    id_sel_e emit_id;
    logic    emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    func_e func;
    logic  free_empty;
    logic  used_empty;
    logic  del_ok;
    logic  head_is_target;
    logic  rd_is_target;
    logic  list_end;
    logic  out_free;
  } dp_sts_t;

endpackage

@@ design/watch_slot_free_list_allocator_core.sv @@
`timescale 1ns / 1ps
// Slot pool allocator: SLOT_COUNT slots held in a used list and a free list that share
// one single-port-read link RAM, so every list step costs one RAM read. Delete walks
// the used list one link at a time until the slot is found, and list emits one result
// per slot, at most 32 results. Results leave through an output register; the block
// waits to emit while that register is full and not taken. Link entries never written
// read as their reset chain through per-entry valid flops, so the block is ready
// straight after reset with no clearing pass.
module watch_slot_free_list_allocator_core import wsfl_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [SLOT_NUM_W-1:0] slot_number_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_ID_W-1:0]  slot_id_o,
  output logic                  last_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  wsfl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  wsfl_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .slot_number_i(slot_number_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_id_o    (slot_id_o),
    .last_o       (last_o)
  );

endmodule

@@ design/wsfl_ram.sv @@
`timescale 1ns / 1ps
module wsfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/wsfl_dp.sv @@
`timescale 1ns / 1ps
module wsfl_dp import wsfl_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [SLOT_NUM_W-1:0] slot_number_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_sts_t               sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_ID_W-1:0]  slot_id_o,
  output logic                  last_o
);

  localparam int IDX_W    = $clog2(SLOT_COUNT);
  localparam int LNK_W    = IDX_W + 1;
  localparam int LIST_MAX = (SLOT_COUNT < MAX_RESULTS) ? SLOT_COUNT : MAX_RESULTS;
  localparam int CNT_W    = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1;
  localparam logic [SLOT_NUM_W:0] SLOT_LIM  = (SLOT_NUM_W + 1)'(SLOT_COUNT);
  localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0]    CNT_LAST  = CNT_W'(LIST_MAX - 1);
  // msb set marks the null link
  localparam logic [LNK_W-1:0]    NIL       = {1'b1, {IDX_W{1'b0}}};

  logic [LNK_W-1:0]      free_head_q, free_head_d;
  logic [LNK_W-1:0]      used_head_q, used_head_d;
  logic [SLOT_COUNT-1:0] in_use_q, in_use_d;
  logic [SLOT_COUNT-1:0] written_q, written_d;
  logic [IDX_W-1:0]      target_q;
  logic [LNK_W-1:0]      s_next_q;
  logic [LNK_W-1:0]      cur_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [IDX_W-1:0]      rd_addr_q;
  logic                  rd_hit_q;
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [SLOT_ID_W-1:0]  slot_id_q;
  logic                  last_q;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [LNK_W-1:0]      wr_data;
  logic [LNK_W-1:0]      ram_rd_data;
  logic [LNK_W-1:0]      link_dflt;
  logic [LNK_W-1:0]      rd_link;
  logic [IDX_W-1:0]      num_idx;
  logic [SLOT_ID_W-1:0]  emit_id;

  assign num_idx = slot_number_i[IDX_W-1:0];

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (cmd_i.rd_sel)
      RD_FREE_HEAD: rd_addr = free_head_q[IDX_W-1:0];
      RD_USED_HEAD: rd_addr = used_head_q[IDX_W-1:0];
      RD_TARGET:    rd_addr = target_q;
      RD_CUR:       rd_addr = cur_q[IDX_W-1:0];
      RD_LINK:      rd_addr = rd_link[IDX_W-1:0];
      default:      rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = NIL;
    case (cmd_i.wr_sel)
      WR_ALLOC: begin
        wr_addr = free_head_q[IDX_W-1:0];
        wr_data = used_head_q;
      end
      WR_UNLINK: begin
        wr_addr = cur_q[IDX_W-1:0];
        wr_data = s_next_q;
      end
      WR_FREE: begin
        wr_addr = target_q;
        wr_data = free_head_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  wsfl_ram #(
    .WIDTH(LNK_W),
    .DEPTH(SLOT_COUNT)
  ) u_link_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(ram_rd_data)
  );

  // An entry never written still holds its reset chain link
  always_comb begin
    if (rd_addr_q == LAST_IDX) begin
      link_dflt = NIL;
    end else begin
      link_dflt = {1'b0, rd_addr_q + IDX_W'(1)};
    end
  end

  assign rd_link = rd_hit_q ? ram_rd_data : link_dflt;

  always_comb begin
    free_head_d = free_head_q;
    used_head_d = used_head_q;
    in_use_d    = in_use_q;
    written_d   = written_q;
    if (wr_en) begin
      written_d[wr_addr] = 1'b1;
    end
    if (cmd_i.alloc_commit) begin
      free_head_d                        = rd_link;
      used_head_d                        = free_head_q;
      in_use_d[free_head_q[IDX_W-1:0]]   = 1'b1;
    end
    if (cmd_i.head_unlink) begin
      used_head_d = rd_link;
    end
    if (cmd_i.free_commit) begin
      free_head_d        = {1'b0, target_q};
      in_use_d[target_q] = 1'b0;
    end
  end

  always_comb begin
    case (cmd_i.emit_id)
      ID_FREE:   emit_id = SLOT_ID_W'(free_head_q[IDX_W-1:0]);
      ID_TARGET: emit_id = SLOT_ID_W'(target_q);
      ID_CUR:    emit_id = SLOT_ID_W'(cur_q[IDX_W-1:0]);
      default:   emit_id = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      used_head_q <= NIL;
      in_use_q    <= '0;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      used_head_q <= used_head_d;
      in_use_q    <= in_use_d;
      written_q   <= written_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      target_q <= num_idx;
    end
    if (cmd_i.snext_load) begin
      s_next_q <= rd_link;
    end
    if (cmd_i.cur_load_head) begin
      cur_q <= used_head_q;
    end else if (cmd_i.cur_load_rd) begin
      cur_q <= rd_link;
    end
    if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
      rd_hit_q  <= written_q[rd_addr];
    end
    if (cmd_i.emit) begin
      status_q  <= cmd_i.emit_status;
      slot_id_q <= emit_id;
      last_q    <= cmd_i.emit_last;
    end
  end

  assign sts_o.func           = func_e'(func_i);
  assign sts_o.free_empty     = free_head_q[IDX_W];
  assign sts_o.used_empty     = used_head_q[IDX_W];
  assign sts_o.del_ok         = ({1'b0, slot_number_i} < SLOT_LIM) && in_use_q[num_idx];
  assign sts_o.head_is_target = (used_head_q == {1'b0, target_q});
  assign sts_o.rd_is_target   = (rd_link == {1'b0, target_q});
  assign sts_o.list_end       = rd_link[IDX_W] || (cnt_q == CNT_LAST);
  assign sts_o.out_free       = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_id_o   = slot_id_q;
  assign last_o      = last_q;

endmodule

@@ design/wsfl_ctrl.sv @@
`timescale 1ns / 1ps
module wsfl_ctrl import wsfl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_AL_WR,
    S_DL_RD,
    S_DL_SN,
    S_DL_WALK,
    S_DL_FREE,
    S_LS_EMIT
  } state_e;

  state_e  state_q, state_d;
  status_e err_q, err_d;

  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    cmd_o   = '{
      capture:       1'b0,
      rd_sel:        RD_NONE,
      wr_sel:        WR_NONE,
      alloc_commit:  1'b0,
      snext_load:    1'b0,
      head_unlink:   1'b0,
      free_commit:   1'b0,
      cur_load_head: 1'b0,
      cur_load_rd:   1'b0,
      cnt_clr:       1'b0,
      cnt_inc:       1'b0,
      emit:          1'b0,
      emit_status:   ST_OK,
      emit_id:       ID_ZERO,
      emit_last:     1'b1
    };
    in_ready_o = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (sts_i.func)
            FUNC_ALLOC: begin
              if (sts_i.free_empty) begin
                err_d   = ST_NO_FREE;
                state_d = S_ERR;
              end else begin
                cmd_o.rd_sel = RD_FREE_HEAD;
                state_d      = S_AL_WR;
              end
            end
            FUNC_DELETE: begin
              if (!sts_i.del_ok) begin
                err_d   = ST_BAD_DEL;
                state_d = S_ERR;
              end else begin
                state_d = S_DL_RD;
              end
            end
            FUNC_LIST: begin
              if (sts_i.used_empty) begin
                err_d   = ST_EMPTY;
                state_d = S_ERR;
              end else begin
                cmd_o.rd_sel        = RD_USED_HEAD;
                cmd_o.cur_load_head = 1'b1;
                cmd_o.cnt_clr       = 1'b1;
                state_d             = S_LS_EMIT;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = err_q;
          state_d           = S_IDLE;
        end
      end

      S_AL_WR: begin
        if (sts_i.out_free) begin
          cmd_o.wr_sel       = WR_ALLOC;
          cmd_o.alloc_commit = 1'b1;
          cmd_o.emit         = 1'b1;
          cmd_o.emit_id      = ID_FREE;
          state_d            = S_IDLE;
        end
      end

      S_DL_RD: begin
        cmd_o.rd_sel = RD_TARGET;
        state_d      = S_DL_SN;
      end

      S_DL_SN: begin
        cmd_o.snext_load = 1'b1;
        if (sts_i.head_is_target) begin
          cmd_o.head_unlink = 1'b1;
          state_d           = S_DL_FREE;
        end else begin
          cmd_o.rd_sel        = RD_USED_HEAD;
          cmd_o.cur_load_head = 1'b1;
          state_d             = S_DL_WALK;
        end
      end

      // Read data is the link of cur; follow it until it points at the target
      S_DL_WALK: begin
        if (sts_i.rd_is_target) begin
          cmd_o.wr_sel = WR_UNLINK;
          state_d      = S_DL_FREE;
        end else begin
          cmd_o.rd_sel      = RD_LINK;
          cmd_o.cur_load_rd = 1'b1;
        end
      end

      S_DL_FREE: begin
        if (sts_i.out_free) begin
          cmd_o.wr_sel      = WR_FREE;
          cmd_o.free_commit = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_id     = ID_TARGET;
          state_d           = S_IDLE;
        end
      end

      // Read data holds the successor of cur, which settles the last flag
      S_LS_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_id   = ID_CUR;
          cmd_o.emit_last = sts_i.list_end;
          if (sts_i.list_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_sel      = RD_LINK;
            cmd_o.cur_load_rd = 1'b1;
            cmd_o.cnt_inc     = 1'b1;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

endmodule

@@ dv/tb_watch_slot_free_list_allocator_core.sv @@
`timescale 1ns / 1ps
module tb_watch_slot_free_list_allocator_core import wsfl_pkg::*;;

  localparam int          SLOT_COUNT = SLOT_COUNT_DEF;
  localparam logic [7:0]  NIL        = 8'hFF;
  localparam int          RAND_OPS   = 452;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          DRAIN_WAIT = 40;

  typedef struct {
    status_e                status;
    logic [SLOT_ID_W-1:0]   slot_id;
    logic                   last;
  } beat_t;

  typedef struct {
    func_e                  func;
    logic [SLOT_NUM_W-1:0]  num;
    bit                     typed;
    status_e                status;
    logic [SLOT_ID_W-1:0]   slot_id;
  } stim_row_t;

  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [FUNC_W-1:0]     func_i        = '0;
  logic [SLOT_NUM_W-1:0] slot_number_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [SLOT_ID_W-1:0]  slot_id_o;
  logic                  last_o;

  // Mirror of the slot lists
  logic [7:0] link_mem [SLOT_COUNT];
  logic [7:0] used_top;
  logic [7:0] free_top;
  bit         slot_busy [SLOT_COUNT];

  beat_t beats_due[$];
  beat_t op_beats[$];
  int    fail_count = 0;
  int    op_count   = 0;
  int    idle_cycles = 0;
  int    rx_hold    = 0;
  bit    steady     = 1'b0;

  // Directed rows: typed expectations only where obvious
  stim_row_t dir_rows [18] = '{
    '{FUNC_LIST,   8'h00, 1'b1, ST_EMPTY,   5'd0},
    '{FUNC_DELETE, 8'h00, 1'b1, ST_BAD_DEL, 5'd0},
    '{FUNC_DELETE, 8'hFF, 1'b1, ST_BAD_DEL, 5'd0},
    '{FUNC_DELETE, 8'd32, 1'b1, ST_BAD_DEL, 5'd0},
    '{FUNC_ALLOC,  8'hFF, 1'b1, ST_OK,      5'd0},
    '{FUNC_ALLOC,  8'h00, 1'b1, ST_OK,      5'd1},
    '{FUNC_ALLOC,  8'h5A, 1'b1, ST_OK,      5'd2},
    '{FUNC_LIST,   8'hA5, 1'b0, ST_OK,      5'd0},
    '{FUNC_DELETE, 8'd1,  1'b0, ST_OK,      5'd0},
    '{FUNC_DELETE, 8'd1,  1'b1, ST_BAD_DEL, 5'd0},
    '{FUNC_DELETE, 8'd2,  1'b0, ST_OK,      5'd0},
    '{FUNC_RSVD,   8'hAA, 1'b0, ST_OK,      5'd0},
    '{FUNC_ALLOC,  8'h00, 1'b0, ST_OK,      5'd0},
    '{FUNC_DELETE, 8'd0,  1'b0, ST_OK,      5'd0},
    '{FUNC_LIST,   8'h00, 1'b0, ST_OK,      5'd0},
    '{FUNC_RSVD,   8'h55, 1'b0, ST_OK,      5'd0},
    '{FUNC_DELETE, 8'd31, 1'b1, ST_BAD_DEL, 5'd0},
    '{FUNC_ALLOC,  8'h00, 1'b0, ST_OK,      5'd0}
  };

  watch_slot_free_list_allocator_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .slot_number_i(slot_number_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_id_o    (slot_id_o),
    .last_o       (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit is_slot(logic [7:0] s);
    return s != NIL && s < SLOT_COUNT;
  endfunction

  function automatic logic [7:0] rand_num();
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_busy_slot();
    logic [7:0] pool[$];
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_busy[i]) pool.push_back(8'(i));
    end
    if (pool.size() == 0) return rand_num();
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  // Apply one operation to the mirrored lists and collect the beats it yields
  task automatic apply_slot_op(input func_e f, input logic [7:0] n, ref beat_t beats[$]);
    logic [7:0] s;
    logic [7:0] cur;
    beats = {};
    case (f)
      FUNC_ALLOC: begin
        if (!is_slot(free_top)) begin
          beats.push_back('{ST_NO_FREE, 5'd0, 1'b1});
        end else begin
          s = free_top;
          free_top = link_mem[s];
          link_mem[s] = used_top;
          used_top = s;
          slot_busy[s] = 1'b1;
          beats.push_back('{ST_OK, s[SLOT_ID_W-1:0], 1'b1});
        end
      end
      FUNC_DELETE: begin
        if (n >= SLOT_COUNT || !slot_busy[n]) begin
          beats.push_back('{ST_BAD_DEL, 5'd0, 1'b1});
        end else begin
          if (used_top == n) begin
            used_top = link_mem[n];
          end else begin
            cur = used_top;
            for (int k = 0; k < SLOT_COUNT && is_slot(cur); k++) begin
              if (link_mem[cur] == n) begin
                link_mem[cur] = link_mem[n];
                break;
              end
              cur = link_mem[cur];
            end
          end
          link_mem[n] = free_top;
          free_top = n;
          slot_busy[n] = 1'b0;
          beats.push_back('{ST_OK, n[SLOT_ID_W-1:0], 1'b1});
        end
      end
      FUNC_LIST: begin
        if (!is_slot(used_top)) begin
          beats.push_back('{ST_EMPTY, 5'd0, 1'b1});
        end else begin
          cur = used_top;
          for (int k = 0; k < SLOT_COUNT && is_slot(cur) && beats.size() < MAX_RESULTS;
               k++) begin
            beats.push_back('{ST_OK, cur[SLOT_ID_W-1:0], 1'b0});
            cur = link_mem[cur];
          end
          beats[beats.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Present one beat and hold it until accepted
  task automatic send_op(input func_e f, input logic [7:0] n);
    int gap;
    gap = steady ? 0 : pick_idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    slot_number_i <= n;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic issue_op(input func_e f, input logic [7:0] n);
    send_op(f, n);
    apply_slot_op(f, n, op_beats);
    foreach (op_beats[j]) beats_due.push_back(op_beats[j]);
    op_count++;
  endtask

  // Receiver stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady) rx_hold = pick_idle_len();
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (beats_due.size() == 0) begin
        $error("unexpected result beat: status %0d slot_id %0d last %0d",
               status_o, slot_id_o, last_o);
        fail_count++;
      end else begin
        want = beats_due.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
        if (slot_id_o !== want.slot_id) begin
          $error("slot_id: expected %0d, actual %0d", want.slot_id, slot_id_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Longest quiet stretch: sender gap + walk of the full list + receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    seg_mode_e  mode;
    int         seg;
    int         r;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      link_mem[i]  = (i + 1 < SLOT_COUNT) ? 8'(i + 1) : NIL;
      slot_busy[i] = 1'b0;
    end
    used_top = NIL;
    free_top = 8'd0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].func, dir_rows[i].num);
      apply_slot_op(dir_rows[i].func, dir_rows[i].num, op_beats);
      if (dir_rows[i].typed) begin
        beats_due.push_back('{dir_rows[i].status, dir_rows[i].slot_id, 1'b1});
      end else begin
        foreach (op_beats[j]) beats_due.push_back(op_beats[j]);
      end
    end

    seg = 0;
    while (op_count < RAND_OPS) begin
      steady = ($urandom_range(0, 3) == 0);
      if (seg == 0 || $urandom_range(0, 5) == 0) mode = SEG_FILL;
      else mode = ($urandom_range(0, 1) == 0) ? SEG_DRAIN : SEG_MIXED;
      if (mode == SEG_FILL) begin
        // exhaust the pool, then hit the empty free list and list all slots
        while (is_slot(free_top)) begin
          if ($urandom_range(0, 9) == 0) issue_op(FUNC_LIST, rand_num());
          issue_op(FUNC_ALLOC, rand_num());
        end
        issue_op(FUNC_ALLOC, rand_num());
        issue_op(FUNC_ALLOC, rand_num());
        issue_op(FUNC_LIST, rand_num());
      end else begin
        repeat ($urandom_range(20, 60)) begin
          if (op_count >= RAND_OPS) break;
          r = $urandom_range(0, 99);
          if (mode == SEG_DRAIN) begin
            if (r < 70)      issue_op(FUNC_DELETE, pick_busy_slot());
            else if (r < 80) issue_op(FUNC_LIST, rand_num());
            else if (r < 88) issue_op(FUNC_ALLOC, rand_num());
            else if (r < 94) issue_op(FUNC_DELETE, rand_num());
            else             issue_op(FUNC_RSVD, rand_num());
          end else begin
            if (r < 35)      issue_op(FUNC_ALLOC, rand_num());
            else if (r < 70) issue_op(FUNC_DELETE, pick_busy_slot());
            else if (r < 85) issue_op(FUNC_LIST, rand_num());
            else if (r < 93) issue_op(FUNC_DELETE, rand_num());
            else             issue_op(FUNC_RSVD, rand_num());
          end
        end
      end
      seg++;
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;

    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && beats_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/wsfl_pkg.sv
design/wsfl_ram.sv
design/wsfl_dp.sv
design/wsfl_ctrl.sv
design/watch_slot_free_list_allocator_core.sv
dv/tb_watch_slot_free_list_allocator_core.sv
